// ===== hw/rtl/bayer_exg_downsample_defines.svh =====
// ----------------------------------------------------------------------------
// bayer excess green downsampler assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BAYER_EXG_DOWNSAMPLE_DEFINES_SVH
`define BAYER_EXG_DOWNSAMPLE_DEFINES_SVH

// same-cycle implication
`define BXD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BXD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bxd_pkg.sv =====
// ----------------------------------------------------------------------------
// bxd_pkg
// types and constants of the bayer excess green downsampler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bxd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;

    // field widths
    localparam int CFG_W     = 13;
    localparam int SAMPLE_W  = 16;
    localparam int INDEX_W   = 8;
    localparam int QSUM_W    = 10;
    localparam int DIFF_W    = 19;
    localparam int MAG_W     = 18;
    localparam int DIVISOR_W = 10;

    // arithmetic constants
    localparam logic [MAG_W-1:0]   SUM_MIN    = 18'd2048;
    localparam int                 SUM_SHIFT  = 8;
    localparam logic signed [19:0] IDX_OFFSET = 20'sd80;
    localparam logic signed [19:0] IDX_MAX    = 20'sd255;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

    // register map
    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_POST,
        ST_PAIR,
        ST_QREAD,
        ST_EMIT
    } t_state;

endpackage

// ===== hw/rtl/bxd_ram.sv =====
// ----------------------------------------------------------------------------
// bxd_ram
// simple dual port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bxd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bayer_exg_downsample.sv =====
// ----------------------------------------------------------------------------
// bayer_exg_downsample
// excess green index of a grbg bayer stream, 2x2 downsampled
// ----------------------------------------------------------------------------
// One raw sample is taken at a time. An item that completes no excess green
// value is only stored; one whose window sum is below the threshold skips the
// divider and pairs a zero value; one that needs a quotient passes through the
// one-bit-per-cycle 18-step divider and post scaling. An item that finishes
// an output pixel also loads the output register, after a read back of the
// upper half-sum from the column store on the lower row of a block; the load
// waits while a previous result is still held. Raw row and half-sum stores
// are block rams with registered reads; they need no clearing after reset. A
// result waits in the output register while the next sample is accepted.
`timescale 1ns / 1ps
`include "bayer_exg_downsample_defines.svh"

module bayer_exg_downsample
    import bxd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample input
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_start_of_frame,
    // result output
    output logic                o_valid,
    input  logic                i_ready,
    output logic [INDEX_W-1:0]  o_green_index,
    output logic                o_end_of_line,
    output logic                o_end_of_frame,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int QDEP = MAX_WIDTH / 2;
    localparam int QW   = $clog2(QDEP);
    localparam int CW   = $clog2(MAG_W + 1);
    localparam logic [CFG_W:0] WLIM = (CFG_W + 1)'(MAX_WIDTH & ~1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]    r_cfg_width, r_cfg_height;
    logic [CFG_W-1:0]    r_col, r_row;
    logic [CFG_W-1:0]    r_x, r_y;
    logic [SAMPLE_W-1:0] r_cur;
    logic [2*SAMPLE_W-1:0] r_left;
    logic [INDEX_W-1:0]  r_left_idx;
    logic signed [DIFF_W-1:0] r_e;
    logic [MAG_W-1:0]    r_s;
    logic                r_neg;
    logic [MAG_W-1:0]    r_quo;
    logic [DIVISOR_W-1:0] r_rem, r_dvs;
    logic [CW-1:0]       r_cnt;
    logic [INDEX_W-1:0]  r_val;
    logic [INDEX_W-1:0]  r_res;
    logic                r_eol, r_eof;
    logic                r_ov;
    logic [INDEX_W-1:0]  r_og;
    logic                r_oeol, r_oeof;

    logic                    cfg_we;
    logic [CFG_W-1:0]        w_eff, h_eff, w_even, h_even;
    logic                    accept;
    logic [CFG_W-1:0]        xs, ys, xc;
    logic [CFG_W:0]          nx, ny;
    logic [SAMPLE_W-1:0]     up_data, tl, bl;
    logic [SAMPLE_W-1:0]     ga, gb, ra, rb;
    logic signed [DIFF_W-1:0] e_sum;
    logic [MAG_W-1:0]        s_sum;
    logic [DIVISOR_W:0]      trial;
    logic signed [19:0]      q_s, v_s;
    logic [CFG_W-1:0]        ex, ey;
    logic [QW-1:0]           ox;
    logic                    last_col;
    logic [INDEX_W-1:0]      pa, pb, qs;
    logic                    eol_c;
    logic                    raw_we;
    logic                    q_we;
    logic [QSUM_W-1:0]       q_rdata;
    logic                    emit_load;

    // effective frame size
    always_comb begin
        w_even = r_cfg_width & ~CFG_W'(1);
        h_even = r_cfg_height & ~CFG_W'(1);
        w_eff  = w_even;
        if (w_even < CFG_W'(2)) begin
            w_eff = CFG_W'(2);
        end else if ({1'b0, w_even} > WLIM) begin
            w_eff = WLIM[CFG_W-1:0];
        end
        h_eff = (h_even < CFG_W'(2)) ? CFG_W'(2) : h_even;
    end

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_HEIGHT) ? {19'd0, r_cfg_height}
                                                        : {19'd0, r_cfg_width};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RESET;
            r_cfg_height <= HEIGHT_RESET;
        end else if (cfg_we) begin
            if (t_reg_idx'(paddr[2]) == REG_HEIGHT) begin
                r_cfg_height <= pwdata[CFG_W-1:0];
            end else begin
                r_cfg_width <= pwdata[CFG_W-1:0];
            end
        end
    end

    // position of the incoming item
    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        xs = i_start_of_frame ? '0 : r_col;
        ys = i_start_of_frame ? '0 : r_row;
        xc = (xs >= w_eff) ? w_eff - CFG_W'(1) : xs;
        nx = {1'b0, xc} + (CFG_W + 1)'(1);
        ny = {1'b0, ys} + (CFG_W + 1)'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (nx >= {1'b0, w_eff}) begin
                r_col <= '0;
                r_row <= (ny >= {1'b0, h_eff}) ? '0 : ny[CFG_W-1:0];
            end else begin
                r_col <= nx[CFG_W-1:0];
                r_row <= ys;
            end
        end
    end

    // raw row store
    assign raw_we = (r_state == ST_READ);

    bxd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (raw_we),
        .i_waddr (r_x[XW-1:0]),
        .i_wdata (r_cur),
        .i_raddr (xc[XW-1:0]),
        .o_rdata (up_data)
    );

    // window sums, greens placed by parity
    always_comb begin
        tl = r_left[2*SAMPLE_W-1:SAMPLE_W];
        bl = r_left[SAMPLE_W-1:0];
        if ((r_x[0] ^ r_y[0]) == 1'b0) begin
            ga = tl;      gb = r_cur; ra = up_data; rb = bl;
        end else begin
            ga = up_data; gb = bl;    ra = tl;      rb = r_cur;
        end
        e_sum = DIFF_W'(ga) + DIFF_W'(gb) - DIFF_W'(ra) - DIFF_W'(rb);
        s_sum = MAG_W'(ga >> 1) + MAG_W'(gb >> 1) + MAG_W'(ra) + MAG_W'(rb);
    end

    // divider step and post scaling
    always_comb begin
        trial = {r_rem, r_quo[MAG_W-1]};
        q_s   = 20'(r_quo);
        v_s   = (r_neg ? -q_s : q_s) + IDX_OFFSET;
    end

    // pair completion
    always_comb begin
        ex       = r_x - CFG_W'(1);
        ey       = r_y - CFG_W'(1);
        ox       = QW'(ex >> 1);
        last_col = (r_x == w_eff - CFG_W'(1));
        if (ex[0] == 1'b0) begin
            pa = r_val;
            pb = '0;
        end else begin
            pa = r_left_idx;
            pb = r_val;
        end
        qs    = (pa >> 2) + (pb >> 2);
        eol_c = ({1'b0, ex[CFG_W-1:1]} == (w_eff >> 1) - CFG_W'(1));
    end

    assign q_we = (r_state == ST_PAIR) && (ey[0] == 1'b0) && (ey != h_eff - CFG_W'(2))
                  && ((ex[0] == 1'b1) || last_col);

    // upper half-sum store
    bxd_ram #(
        .WIDTH (QSUM_W),
        .DEPTH (QDEP)
    ) u_qsum_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (ox),
        .i_wdata (QSUM_W'(qs)),
        .i_raddr (ox),
        .o_rdata (q_rdata)
    );

    assign emit_load = (r_state == ST_EMIT) && (!r_ov || i_ready);

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (accept) n_state = ST_READ;
            ST_READ:  n_state = ((r_x != '0) && (r_y != '0)) ? ST_CALC : ST_IDLE;
            ST_CALC:  n_state = (r_s < SUM_MIN) ? ST_PAIR : ST_DIV;
            ST_DIV:   if (r_cnt == CW'(1)) n_state = ST_POST;
            ST_POST:  n_state = ST_PAIR;
            ST_PAIR: begin
                if ((ex[0] == 1'b0) && !last_col) begin
                    n_state = ST_IDLE;
                end else if (ey[0] == 1'b1) begin
                    n_state = ST_QREAD;
                end else if (ey == h_eff - CFG_W'(2)) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_QREAD: n_state = ST_EMIT;
            ST_EMIT:  if (emit_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // left samples and left value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left     <= '0;
            r_left_idx <= '0;
        end else begin
            if (r_state == ST_READ) begin
                r_left <= {up_data, r_cur};
            end
            if ((r_state == ST_PAIR) && (ex[0] == 1'b0)) begin
                r_left_idx <= r_val;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x   <= xc;
            r_y   <= ys;
            r_cur <= i_sample;
        end
        case (r_state)
            ST_READ: begin
                r_e <= e_sum;
                r_s <= s_sum;
            end
            ST_CALC: begin
                r_val <= '0;
                r_neg <= r_e[DIFF_W-1];
                r_quo <= r_e[DIFF_W-1] ? MAG_W'(-r_e) : MAG_W'(r_e);
                r_dvs <= r_s[MAG_W-1:SUM_SHIFT];
                r_rem <= '0;
                r_cnt <= CW'(MAG_W);
            end
            ST_DIV: begin
                if (trial >= {1'b0, r_dvs}) begin
                    r_rem <= DIVISOR_W'(trial - {1'b0, r_dvs});
                    r_quo <= {r_quo[MAG_W-2:0], 1'b1};
                end else begin
                    r_rem <= trial[DIVISOR_W-1:0];
                    r_quo <= {r_quo[MAG_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - CW'(1);
            end
            ST_POST: begin
                if (v_s > IDX_MAX) begin
                    r_val <= INDEX_W'(IDX_MAX);
                end else if (v_s < 0) begin
                    r_val <= '0;
                end else begin
                    r_val <= v_s[INDEX_W-1:0];
                end
            end
            ST_PAIR: begin
                r_res <= qs;
                r_eol <= eol_c;
                r_eof <= eol_c && (ey[0] == 1'b0);
            end
            ST_QREAD: begin
                r_res <= INDEX_W'(q_rdata + QSUM_W'(r_res));
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_og   <= r_res;
            r_oeol <= r_eol;
            r_oeof <= r_eof;
        end
    end

    assign o_valid        = r_ov;
    assign o_green_index  = r_og;
    assign o_end_of_line  = r_oeol;
    assign o_end_of_frame = r_oeof;

    // checks
    `BXD_ASSERT_NXT(a_one_item, i_valid && o_ready, !o_ready, "second item taken while busy")
    `BXD_ASSERT_IMP(a_col_range, r_state == ST_READ, r_x < w_eff, "column beyond frame width")
    `BXD_ASSERT_IMP(a_div_count, r_state == ST_DIV, r_cnt != '0, "divider ran past its steps")

endmodule

// ===== dv/bayer_exg_checker.sv =====
// ----------------------------------------------------------------------------
// bayer_exg_checker
// predicts the downsampled excess green stream from accepted samples and
// register writes, and compares every accepted result with it in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bayer_exg_checker
    import bxd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_start_of_frame,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [INDEX_W-1:0]  i_green_index,
    input  logic                i_end_of_line,
    input  logic                i_end_of_frame,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam int ROW_DEPTH = MAX_WIDTH_DEF;

    typedef struct {
        logic [INDEX_W-1:0] green_index;
        logic               end_of_line;
        logic               end_of_frame;
    } t_pixel;

    t_pixel             expected_pixels[$];
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    int                 col;
    int                 row;
    logic [31:0]        left_pair;
    int                 left_value;
    logic [15:0]        raw_line[ROW_DEPTH];
    logic [15:0]        half_sums[ROW_DEPTH/2];

    assign o_pending = expected_pixels.size();

    // effective frame size after rounding and clamping
    function automatic int eff_width(logic [CFG_W-1:0] r);
        int w;
        w = int'(r) & ~1;
        if (w < 2) w = 2;
        if (w > ROW_DEPTH) w = ROW_DEPTH;
        return w;
    endfunction

    function automatic int eff_height(logic [CFG_W-1:0] r);
        int h;
        h = int'(r) & ~1;
        if (h < 2) h = 2;
        return h;
    endfunction

    // normalized excess green of one 2x2 window
    function automatic int excess_green(int ga, int gb, int ra, int rb);
        int e;
        int s;
        int v;
        e = ga + gb - ra - rb;
        s = ga / 2 + gb / 2 + ra + rb;
        if (s < 2048) return 0;
        v = e / (s >>> 8) + 80;
        if (v > 255) v = 255;
        if (v < 0) v = 0;
        return v;
    endfunction

    // close a horizontal pair of values; emit on the lower row of a block or on the last value row
    task automatic close_pair(int ox, int a, int b, int ey, int w, int h);
        int     qs;
        t_pixel p;
        qs = a / 4 + b / 4;
        p.end_of_line = (ox == w / 2 - 1);
        if ((ey & 1) == 0) begin
            if (ey == h - 2) begin
                p.green_index  = qs[7:0];
                p.end_of_frame = p.end_of_line;
                expected_pixels.push_back(p);
            end else begin
                half_sums[ox % (ROW_DEPTH/2)] = qs[15:0];
            end
        end else begin
            qs = qs + int'(half_sums[ox % (ROW_DEPTH/2)]);
            p.green_index  = qs[7:0];
            p.end_of_frame = 1'b0;
            expected_pixels.push_back(p);
        end
    endtask

    // advance the predictor by one raw sample
    task automatic take_sample(int cur, logic sof);
        int w;
        int h;
        int x;
        int y;
        int up;
        int tl;
        int bl;
        int e;
        w = eff_width(width_reg);
        h = eff_height(height_reg);
        if (sof) begin
            col = 0;
            row = 0;
        end
        x = col;
        y = row;
        if (x >= w) x = w - 1;
        up = raw_line[x % ROW_DEPTH];
        tl = left_pair[31:16];
        bl = left_pair[15:0];
        if (y >= 1 && x >= 1) begin
            if ((((x - 1) + (y - 1)) & 1) == 0) e = excess_green(tl, cur, up, bl);
            else e = excess_green(up, bl, tl, cur);
            if (((x - 1) & 1) == 0) begin
                left_value = e;
                if (x == w - 1) close_pair((x - 1) / 2, e, 0, y - 1, w, h);
            end else begin
                close_pair((x - 1) / 2, left_value, e, y - 1, w, h);
            end
        end
        raw_line[x % ROW_DEPTH] = cur[15:0];
        left_pair = {up[15:0], cur[15:0]};
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col = x;
        row = y;
    endtask

    initial begin
        for (int i = 0; i < ROW_DEPTH; i++) raw_line[i] = '0;
        for (int i = 0; i < ROW_DEPTH/2; i++) half_sums[i] = '0;
    end

    // watch config, sample and result channels
    always @(posedge i_clk) begin
        t_pixel exp_p;
        if (!i_rst_n) begin
            width_reg    <= WIDTH_RESET;
            height_reg   <= HEIGHT_RESET;
            col          = 0;
            row          = 0;
            left_pair    = '0;
            left_value   = 0;
            o_fail_count = 0;
            expected_pixels.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (t_reg_idx'(i_paddr[2]) == REG_WIDTH) width_reg <= i_pwdata[CFG_W-1:0];
                else height_reg <= i_pwdata[CFG_W-1:0];
                col = 0;
                row = 0;
            end
            if (i_in_valid && i_in_ready) take_sample(int'(i_sample), i_start_of_frame);
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result item with nothing expected: green_index %0d", i_green_index);
                    o_fail_count++;
                end else begin
                    exp_p = expected_pixels.pop_front();
                    if (i_green_index !== exp_p.green_index) begin
                        $error("green_index expected %0d actual %0d",
                               exp_p.green_index, i_green_index);
                        o_fail_count++;
                    end
                    if (i_end_of_line !== exp_p.end_of_line) begin
                        $error("end_of_line expected %0d actual %0d",
                               exp_p.end_of_line, i_end_of_line);
                        o_fail_count++;
                    end
                    if (i_end_of_frame !== exp_p.end_of_frame) begin
                        $error("end_of_frame expected %0d actual %0d",
                               exp_p.end_of_frame, i_end_of_frame);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives raw bayer frames and register writes into the downsampler under
// random idling on both channels; the checker predicts and compares results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import bxd_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 40;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [SAMPLE_W-1:0] i_sample;
    logic                i_start_of_frame;
    logic                o_valid;
    logic                i_ready;
    logic [INDEX_W-1:0]  o_green_index;
    logic                o_end_of_line;
    logic                o_end_of_frame;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int samples_sent;
    int quiet_cycles;

    bayer_exg_downsample i_dut (.*);

    bayer_exg_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_sample        (i_sample),
        .i_start_of_frame(i_start_of_frame),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_green_index   (o_green_index),
        .i_end_of_line   (o_end_of_line),
        .i_end_of_frame  (o_end_of_frame),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no accepted item
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // idling follows the sample count
    always @(posedge i_clk) begin
        if (samples_sent < 300) begin
            send_idle_pct  <= 14;
            recv_stall_pct <= 59;
        end else if (samples_sent < 600) begin
            send_idle_pct  <= 59;
            recv_stall_pct <= 14;
        end else begin
            send_idle_pct  <= 0;
            recv_stall_pct <= 0;
        end
    end

    // one sample item, held until accepted
    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic sof);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_sample         <= s;
        i_start_of_frame <= sof;
        do @(posedge i_clk); while (!o_ready);
        samples_sent++;
    endtask

    // register write once all results are out and the pipe has drained
    task automatic write_reg(t_reg_idx idx, logic [31:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // sample content by style; green sites sit where x+y is even
    function automatic logic [SAMPLE_W-1:0] pick_sample(int style, int x, int y);
        logic green;
        green = ((x + y) % 2) == 0;
        case (style)
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(1500));
            2: return green ? SAMPLE_W'($urandom_range(65535, 20000))
                            : SAMPLE_W'($urandom_range(4000));
            3: return green ? SAMPLE_W'($urandom_range(4000))
                            : SAMPLE_W'($urandom_range(65535, 20000));
            4: return $urandom_range(1) ? 16'hffff : 16'h0000;
            default: return SAMPLE_W'($urandom_range(1100, 400));
        endcase
    endfunction

    // a frame of count samples; marker and noise options make broken frames
    task automatic send_frame(int w, int h, int count, int style, logic marked);
        int  x;
        int  y;
        logic sof;
        x = 0;
        y = 0;
        for (int i = 0; i < count; i++) begin
            sof = (i == 0) ? marked : ($urandom_range(299) == 0);
            if (sof) begin
                x = 0;
                y = 0;
            end
            send_sample(pick_sample(style, x, y), sof);
            x++;
            if (x >= w) begin
                x = 0;
                y = (y + 1) % h;
            end
        end
    endtask

    initial begin
        int wr;
        int hr;
        int w;
        int h;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_sample         <= '0;
        i_start_of_frame <= 1'b0;
        i_ready          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        samples_sent     = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: green heavy, red heavy, all dark
        write_reg(REG_WIDTH, 4);
        write_reg(REG_HEIGHT, 2);
        send_frame(4, 2, 8, 2, 1'b1);
        send_frame(4, 2, 8, 3, 1'b1);
        for (int i = 0; i < 8; i++) send_sample(16'h0000, i == 0);

        // random frames of small sizes, odd and tiny register values included
        while (samples_sent < 650) begin
            wr = $urandom_range(24);
            hr = $urandom_range(10);
            write_reg(REG_WIDTH, wr);
            write_reg(REG_HEIGHT, hr);
            w = (wr & ~1) < 2 ? 2 : (wr & ~1);
            h = (hr & ~1) < 2 ? 2 : (hr & ~1);
            repeat ($urandom_range(3, 1)) begin
                case ($urandom_range(9))
                    0:       send_frame(w, h, $urandom_range(w * h), $urandom_range(5), 1'b1);
                    1:       send_frame(w, h, w * h, $urandom_range(5), 1'b0);
                    default: send_frame(w, h, w * h, $urandom_range(5), 1'b1);
                endcase
            end
        end

        // largest width, smallest height: a cut frame
        write_reg(REG_WIDTH, 13'h1fff);
        write_reg(REG_HEIGHT, 0);
        send_frame(4096, 2, 64, 0, 1'b1);

        // tallest height, narrowest width: a cut frame, then two full small ones
        write_reg(REG_WIDTH, 1);
        write_reg(REG_HEIGHT, 13'h1fff);
        send_frame(2, 8190, 120, 0, 1'b1);
        write_reg(REG_HEIGHT, 1);
        send_frame(2, 2, 4, 0, 1'b1);
        send_frame(2, 2, 4, 4, 1'b0);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
